// ----- hw/rtl/sha256_pkg.sv -----
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       message_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic       load_byte;
		logic [7:0] load_value;
		logic       count_byte;
		logic       start_block;
		logic       round_step;
		logic       finish_block;
		logic       reset_chain;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
		logic [63:0] bit_length;
	} dp_status_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

	function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
		ror32 = (v >> n) | (v << (32 - n));
	endfunction

endpackage

// ----- hw/rtl/sha256_datapath.sv -----
module sha256_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::dp_cmd_t    cmd,
	output sha256_pkg::dp_status_t status,
	output logic [31:0]            emit_words [8]
);
	import sha256_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  fill_q;
	logic [5:0]  round_q;
	logic [60:0] count_q;

	logic [31:0] w_new, t1, t2, s0, s1;

	always_comb begin
		s0 = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		t1 = v_q[7] + (ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[round_q] + w_q[0];
		t2 = (ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], cmd.load_value};
		end else if (cmd.round_step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
		if (cmd.start_block) begin
			v_q <= h_q;
		end else if (cmd.round_step) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= INIT_H;
			fill_q  <= '0;
			round_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load_byte) fill_q <= fill_q + 6'd1;
			if (cmd.count_byte) count_q <= count_q + 61'd1;
			if (cmd.start_block) round_q <= '0;
			else if (cmd.round_step) round_q <= round_q + 6'd1;
			if (cmd.reset_chain) begin
				h_q     <= INIT_H;
				fill_q  <= '0;
				count_q <= '0;
			end else if (cmd.finish_block) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	assign status.fill       = fill_q;
	assign status.round_last = (round_q == 6'd63);
	assign status.bit_length = {count_q, 3'b000};
	assign emit_words        = h_q;
endmodule

// ----- hw/rtl/sha256_control.sv -----
module sha256_control (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha256_pkg::in_item_t   in_item,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [2:0]             word_idx,
	input  sha256_pkg::dp_status_t status,
	output sha256_pkg::dp_cmd_t    cmd
);
	import sha256_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        end_q, end_d;
	logic        mark_q, mark_d;
	logic [2:0]  idx_q, idx_d;
	logic        fin_q, fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
			mark_q  <= 1'b0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			end_q   <= end_d;
			mark_q  <= mark_d;
			idx_q   <= idx_d;
			fin_q   <= fin_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		end_d    = end_q;
		mark_d   = mark_q;
		idx_d    = idx_q;
		fin_d    = fin_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_byte  = in_item.byte_valid;
					cmd.load_value = in_item.data_byte;
					cmd.count_byte = in_item.byte_valid;
					end_d  = in_item.message_end;
					mark_d = 1'b0;
					if (in_item.byte_valid && status.fill == 6'd63) begin
						cmd.start_block = 1'b1;
						fin_d   = 1'b0;
						state_d = ST_ROUND;
					end else if (in_item.message_end) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				if (status.round_last) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.finish_block = 1'b1;
				if (fin_q) begin
					idx_d   = '0;
					state_d = ST_EMIT;
				end else if (end_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD: begin
				cmd.load_byte = 1'b1;
				if (!mark_q) begin
					cmd.load_value = PAD_MARK;
					mark_d = 1'b1;
				end else if (status.fill >= LEN_OFFSET && fin_q) begin
					cmd.load_value = status.bit_length[8*(7 - (status.fill - LEN_OFFSET)) +: 8];
				end else begin
					cmd.load_value = 8'h00;
				end
				if (status.fill == LEN_OFFSET - 6'd1) fin_d = 1'b1;
				if (status.fill == 6'd63) begin
					cmd.start_block = 1'b1;
					state_d = ST_ROUND;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.reset_chain = 1'b1;
						end_d   = 1'b0;
						fin_d   = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign word_idx = idx_q;
endmodule

// ----- hw/rtl/sha256_message_hash.sv -----
// SHA-256 hasher over a byte stream.
// Input channel (in_valid/in_ready, in_item): one request carries an optional
// message byte and an optional end-of-message mark. The byte is absorbed
// before the mark takes effect.
// Output channel (out_valid/out_ready, out_item): after each end mark the
// eight digest words are sent, word 0 first, last_word set on word 7.
// Flow: bytes that do not complete a 64-byte block are taken one per cycle;
// the 64th byte starts the compression, 64 rounds, one per cycle, through the
// single round unit and then a fold of the result into the chaining words,
// and input is refused until the fold is done. Padding writes one byte per
// cycle into the block buffer, then runs one or two more compressions, after
// which the eight digest words are sent one per cycle while the receiver
// does not stall.
// Input is refused while a block compresses, while padding, and while the
// digest words are sent; a stall on the output simply holds the current word.
// Reset loads the initial chaining values and clears the byte counts; the
// block buffer needs no clearing since each entry is written before use.
module sha256_message_hash (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sha256_pkg::in_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha256_pkg::out_item_t out_item
);
	import sha256_pkg::*;

	dp_cmd_t     cmd;
	dp_status_t  status;
	logic [31:0] words [8];
	logic [2:0]  word_idx;

	sha256_control u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.word_idx  (word_idx),
		.status    (status),
		.cmd       (cmd)
	);

	sha256_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.emit_words (words)
	);

	assign out_item.digest_word = words[word_idx];
	assign out_item.word_number = word_idx;
	assign out_item.last_word   = (word_idx == 3'd7);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input and output active together");
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_item.last_word |=> in_ready)
		else $error("no return to idle after digest");
	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_item.last_word |=>
		out_valid && out_item.word_number == $past(out_item.word_number) + 3'd1)
		else $error("digest word order broken");
endmodule
